>>> rtl/ip_to_port_learning_table_defines.svh
// ----------------------------------------------------------------------------
// ip_to_port_learning_table_defines
// Assertion macros shared by the learning table modules.
// ----------------------------------------------------------------------------
`ifndef IP_TO_PORT_LEARNING_TABLE_DEFINES_SVH
`define IP_TO_PORT_LEARNING_TABLE_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define IPLT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define IPLT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/iplt_pkg.sv
// ----------------------------------------------------------------------------
// iplt_pkg
// Types and constants for the IP to tunnel endpoint learning table.
// ----------------------------------------------------------------------------
package iplt_pkg;

   // request kinds
   localparam logic REQ_LEARN  = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   // IP header version codes
   localparam logic [3:0] IP_V4 = 4'd4;
   localparam logic [3:0] IP_V6 = 4'd6;

   // result status codes
   localparam logic [2:0] ST_DONE  = 3'd0;
   localparam logic [2:0] ST_KNOWN = 3'd1;
   localparam logic [2:0] ST_OWN   = 3'd2;
   localparam logic [2:0] ST_NOTIP = 3'd3;
   localparam logic [2:0] ST_FULL  = 3'd4;

   // request beat
   typedef struct packed {
      logic        req_type;
      logic [3:0]  ip_version;
      logic [63:0] addr_upper;
      logic [63:0] addr_lower;
      logic [31:0] origin_node;
      logic [31:0] origin_port;
   } iplt_req_type;

   // result beat
   typedef struct packed {
      logic [2:0]  status;
      logic        hit;
      logic        use_multicast;
      logic [31:0] dest_node;
      logic [31:0] dest_port;
   } iplt_rsp_type;

   // one table entry: key and endpoint
   typedef struct packed {
      logic        is_v6;
      logic [63:0] addr_upper;
      logic [63:0] addr_lower;
      logic [31:0] node;
      logic [31:0] port;
   } iplt_entry_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request, restart scan
      logic step;       // read next entry
      logic write;      // insert captured key at fill point
      logic resp_load;  // load output register
   } iplt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic early;       // result decided without a scan
      logic more;        // entries left to read
      logic rd_pending;  // a read is in flight
      logic match;       // the entry just read matches the key
      logic can_insert;  // learn request and room in the table
      logic out_free;    // output register can take a result
   } iplt_stat_type;

endpackage

>>> rtl/iplt_dp.sv
// ----------------------------------------------------------------------------
// iplt_dp
// Datapath: request capture, entry memory, scan compare, output register.
// ----------------------------------------------------------------------------
`include "ip_to_port_learning_table_defines.svh"

module iplt_dp import iplt_pkg::*; #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  iplt_req_type  req_data,
   input  logic          csr_valid,
   input  logic [31:0]   csr_data,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output iplt_rsp_type  rsp_data,
   input  iplt_cmd_type  cmd,
   output iplt_stat_type stat
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TABLE_ENTRIES);

   // captured request, key already normalised
   typedef struct packed {
      logic        req_type;
      logic        ip_ok;
      logic        is_v6;
      logic [63:0] addr_upper;
      logic [63:0] addr_lower;
      logic [31:0] origin_node;
      logic [31:0] origin_port;
   } iplt_cap_type;

   iplt_entry_type entry_mem [TABLE_ENTRIES];

   iplt_cap_type   cap_ff, cap_in;
   iplt_entry_type rd_entry_ff;
   iplt_rsp_type   rsp_ff, rsp_in;
   logic [31:0]    own_node_ff;
   logic [CNT_W-1:0] fill_count_ff;
   logic [CNT_W-1:0] scan_idx_ff;
   logic           rd_valid_ff;
   logic           found_ff;
   logic           wrote_ff;
   logic           rsp_valid_ff;
   logic           is_v6;
   logic           own_origin;
   logic           match;
   iplt_entry_type wr_entry;

   // key normalisation: IPv4 keeps only the low 32 bits
   always_comb begin
      is_v6               = (req_data.ip_version == IP_V6);
      cap_in.req_type     = req_data.req_type;
      cap_in.ip_ok        = (req_data.ip_version == IP_V4) || is_v6;
      cap_in.is_v6        = is_v6;
      cap_in.addr_upper   = is_v6 ? req_data.addr_upper : 64'd0;
      cap_in.addr_lower   = is_v6 ? req_data.addr_lower : {32'd0, req_data.addr_lower[31:0]};
      cap_in.origin_node  = req_data.origin_node;
      cap_in.origin_port  = req_data.origin_port;
   end

   // compare of the entry read last cycle
   assign match = rd_valid_ff
                  && (rd_entry_ff.is_v6 == cap_ff.is_v6)
                  && (rd_entry_ff.addr_upper == cap_ff.addr_upper)
                  && (rd_entry_ff.addr_lower == cap_ff.addr_lower);

   assign own_origin = (cap_ff.origin_node == own_node_ff);

   always_comb begin
      wr_entry.is_v6      = cap_ff.is_v6;
      wr_entry.addr_upper = cap_ff.addr_upper;
      wr_entry.addr_lower = cap_ff.addr_lower;
      wr_entry.node       = cap_ff.origin_node;
      wr_entry.port       = cap_ff.origin_port;
   end

   // status to the controller
   always_comb begin
      stat.early      = (cap_ff.req_type == REQ_LEARN) ? (own_origin || !cap_ff.ip_ok)
                                                       : !cap_ff.ip_ok;
      stat.more       = (scan_idx_ff != fill_count_ff);
      stat.rd_pending = rd_valid_ff;
      stat.match      = match;
      stat.can_insert = (cap_ff.req_type == REQ_LEARN) && (fill_count_ff != CNT_MAX);
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // result assembly
   always_comb begin
      rsp_in               = '0;
      if (cap_ff.req_type == REQ_LEARN) begin
         priority if (own_origin) begin
            rsp_in.status = ST_OWN;
         end else if (!cap_ff.ip_ok) begin
            rsp_in.status = ST_NOTIP;
         end else if (found_ff) begin
            rsp_in.status = ST_KNOWN;
         end else if (!wrote_ff) begin
            rsp_in.status = ST_FULL;
         end else begin
            rsp_in.status = ST_DONE;
         end
      end else begin
         priority if (!cap_ff.ip_ok) begin
            rsp_in.status        = ST_NOTIP;
            rsp_in.use_multicast = 1'b1;
         end else if (found_ff) begin
            rsp_in.status    = ST_DONE;
            rsp_in.hit       = 1'b1;
            rsp_in.dest_node = rd_entry_ff.node;
            rsp_in.dest_port = rd_entry_ff.port;
         end else begin
            rsp_in.status        = ST_DONE;
            rsp_in.use_multicast = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_node_ff   <= '0;
         fill_count_ff <= '0;
         scan_idx_ff   <= '0;
         rd_valid_ff   <= 1'b0;
         found_ff      <= 1'b0;
         wrote_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            own_node_ff <= csr_data;
         end
         rd_valid_ff <= cmd.step;
         if (cmd.load) begin
            scan_idx_ff <= '0;
            found_ff    <= 1'b0;
            wrote_ff    <= 1'b0;
         end else begin
            if (cmd.step) begin
               scan_idx_ff <= scan_idx_ff + CNT_W'(1);
            end
            if (match) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.write) begin
            fill_count_ff <= fill_count_ff + CNT_W'(1);
            wrote_ff      <= 1'b1;
         end
         if (cmd.resp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // entry memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         entry_mem[fill_count_ff[IDX_W-1:0]] <= wr_entry;
      end
      if (cmd.step) begin
         rd_entry_ff <= entry_mem[scan_idx_ff[IDX_W-1:0]];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cap_ff <= cap_in;
      end
      if (cmd.resp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `IPLT_ASSERT_NOW(a_fill_bound, 1'b1, fill_count_ff <= CNT_MAX, "fill count past table size")
   `IPLT_ASSERT_NOW(a_write_room, cmd.write, fill_count_ff != CNT_MAX, "insert into full table")
   `IPLT_ASSERT_NOW(a_hit_xor_mc, rsp_valid_ff, !(rsp_ff.hit && rsp_ff.use_multicast),
                    "hit and multicast both set")
   `IPLT_ASSERT_NEXT(a_write_grows, cmd.write, fill_count_ff == $past(fill_count_ff) + CNT_W'(1),
                     "fill count did not advance on insert")

endmodule

>>> rtl/iplt_ctrl.sv
// ----------------------------------------------------------------------------
// iplt_ctrl
// Sequencer: accept, scan the table, insert on a learn miss with room, deliver result.
// ----------------------------------------------------------------------------
`include "ip_to_port_learning_table_defines.svh"

module iplt_ctrl import iplt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  iplt_stat_type stat,
   output iplt_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_WRITE,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;

   // commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid && req_ready_ff;
            if (cmd.load) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            priority if (stat.early || stat.match) begin
               state_in = S_RESP;
            end else if (stat.more) begin
               cmd.step = 1'b1;
            end else if (!stat.rd_pending) begin
               // scan finished without a match
               state_in = stat.can_insert ? S_WRITE : S_RESP;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.resp_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == S_IDLE) && !cmd.load;
      end
   end

   assign req_ready = req_ready_ff;

   `IPLT_ASSERT_NOW(a_step_in_range, cmd.step, stat.more, "read past fill point")
   `IPLT_ASSERT_NOW(a_write_ok, cmd.write, stat.can_insert, "insert without room")
   `IPLT_ASSERT_NOW(a_resp_free, cmd.resp_load, stat.out_free, "result overwrites pending beat")
   `IPLT_ASSERT_NEXT(a_load_busy, cmd.load, !req_ready_ff, "ready held after accept")

endmodule

>>> rtl/ip_to_port_learning_table.sv
// ----------------------------------------------------------------------------
// ip_to_port_learning_table
// Learns IP address to tunnel endpoint mappings and answers lookups.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one request beat per item (learn source address or look up
//            destination address), valid/ready.
//   rsp_*  : one result beat per request, in order, valid/ready.
//   csr_*  : write of own_node; always ready, take it only while idle.
// Scan: the filled part of the table is scanned one entry a cycle through
//   the single read port, stopping early on a match. A learn miss with
//   room then inserts the key at the fill point. A bad version, an
//   own-origin learn or an empty table needs no read of the table.
//   One item is worked at a time.
// Reset: synchronous; empties the table (fill count to zero), clears
//   own_node and drops any pending result. No clearing pass is needed.
// Stall: a finished result waits in the output register; the next request
//   is accepted and scanned meanwhile, and only its delivery waits.
// ----------------------------------------------------------------------------
module ip_to_port_learning_table import iplt_pkg::*; #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  iplt_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output iplt_rsp_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data
);

   iplt_cmd_type  cmd;
   iplt_stat_type stat;

   // register port never stalls
   assign csr_ready = 1'b1;

   iplt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   iplt_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule
